[rtl/ptct_pkg.sv]
// Package: shared constants, types and state codes for the priority task scheduler.
package ptct_pkg;

  localparam int MAX_TASKS = 64;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DONE_W    = 39;
  localparam int OUT_IDX_W = 6;
  localparam int IN_W      = 64;
  localparam int OUT_W     = 48;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_IDX,
    ST_ARR,
    ST_CMP_A,
    ST_CMP_F,
    ST_MAX,
    ST_ADD,
    ST_OUT_RD,
    ST_OUT
  } ptct_state_e;

  typedef struct packed {
    logic [DONE_W-1:0] a;
    logic [DONE_W-1:0] b;
  } ptct_opnd_t;

  typedef struct packed {
    logic              lt;
    logic [DONE_W-1:0] sum;
  } ptct_res_t;

endpackage

[rtl/ptct_unit.sv]
// Shared compare and saturating add unit for the scheduler.
module ptct_unit (
  input  ptct_pkg::ptct_opnd_t opnd_i,
  output ptct_pkg::ptct_res_t  res_o
);
  import ptct_pkg::*;

  logic [DONE_W:0] sum_full;

  assign sum_full = {1'b0, opnd_i.a} + {1'b0, opnd_i.b};

  always_comb begin
    res_o.lt  = (opnd_i.a < opnd_i.b);
    res_o.sum = sum_full[DONE_W] ? {DONE_W{1'b1}} : sum_full[DONE_W-1:0];
  end

endmodule

[rtl/priority_task_completion_times.sv]
// Top level: non-preemptive two-class priority scheduler giving per-task completion times.
//
//  channel  | direction | tdata (low bit up)                   | tuser     | tlast
//  s_axis   | in        | arrival_time[31:0], service_time[31:0] | low_class | last_task
//  m_axis   | out       | task_index[5:0], completion_time[38:0] | -         | last_result
//
// Loading takes one task per cycle. After the last task (or the 64th) the
// schedule takes each task through states IDX, ARR, CMP_A, CMP_F, MAX, ADD on the shared
// compare/add unit, then each result through a completion memory read and its transfer.
// s_axis_tready_o is low from the end of a batch until its final result is taken.
// Reset clears counts, free time and state only; memories hold no reset value.
module priority_task_completion_times (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [ptct_pkg::IN_W-1:0] s_axis_tdata_i,   // arrival_time, service_time
  input  logic                    s_axis_tuser_i,   // low_class
  input  logic                    s_axis_tlast_i,   // last_task
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [ptct_pkg::OUT_W-1:0] m_axis_tdata_o,  // task_index, completion_time, zero pad
  output logic                    m_axis_tlast_o    // last_result
);
  import ptct_pkg::*;

  localparam int PAD_W = DONE_W - TIME_BITS;

  ptct_state_e state_q, state_d;

  logic [TIME_BITS-1:0] arr_mem [MAX_TASKS];
  logic [TIME_BITS-1:0] svc_mem [MAX_TASKS];
  logic [IDX_W-1:0]     hi_list [MAX_TASKS];
  logic [IDX_W-1:0]     lo_list [MAX_TASKS];
  logic [DONE_W-1:0]    cmp_mem [MAX_TASKS];

  logic [CNT_W-1:0] loaded_q, hc_q, lc_q, h_q, l_q, k_q;
  logic [DONE_W-1:0] free_q, start_q;
  logic [IDX_W-1:0]  hi_idx_q, lo_idx_q, sel_idx_q;
  logic [TIME_BITS-1:0] hi_arr_q, lo_arr_q, hi_svc_q, lo_svc_q;
  logic [DONE_W-1:0] sel_arr_q, sel_svc_q, rd_q;
  logic flag_q, take_low_q;

  logic in_xfer, out_xfer, batch_end, take_low, h_has, l_has;
  logic [CNT_W-1:0] h_nxt, l_nxt;
  ptct_opnd_t opnd;
  ptct_res_t  res;

  ptct_unit u_unit (
    .opnd_i(opnd),
    .res_o (res)
  );

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign batch_end = s_axis_tlast_i || (loaded_q == CNT_W'(MAX_TASKS - 1));

  assign h_has = (h_q < hc_q);
  assign l_has = (l_q < lc_q);
  assign take_low = l_has && (!h_has || (flag_q && res.lt));
  assign h_nxt = take_low_q ? h_q : h_q + 1'b1;
  assign l_nxt = take_low_q ? l_q + 1'b1 : l_q;

  assign m_axis_tdata_o = {{(OUT_W - OUT_IDX_W - DONE_W){1'b0}}, rd_q, k_q[OUT_IDX_W-1:0]};
  assign m_axis_tlast_o = (k_q == loaded_q - 1'b1);

  always_comb begin
    opnd.a = free_q;
    opnd.b = {{PAD_W{1'b0}}, hi_arr_q};
    case (state_q)
      ST_CMP_A: begin
        opnd.a = {{PAD_W{1'b0}}, lo_arr_q};
      end
      ST_MAX: begin
        opnd.b = sel_arr_q;
      end
      ST_ADD: begin
        opnd.a = start_q;
        opnd.b = sel_svc_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:   if (in_xfer && batch_end) state_d = ST_IDX;
      ST_IDX:    state_d = ST_ARR;
      ST_ARR:    state_d = ST_CMP_A;
      ST_CMP_A:  state_d = ST_CMP_F;
      ST_CMP_F:  state_d = ST_MAX;
      ST_MAX:    state_d = ST_ADD;
      ST_ADD:    state_d = ((h_nxt < hc_q) || (l_nxt < lc_q)) ? ST_IDX : ST_OUT_RD;
      ST_OUT_RD: state_d = ST_OUT;
      ST_OUT:    if (out_xfer) state_d = m_axis_tlast_o ? ST_LOAD : ST_OUT_RD;
      default:   state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      hc_q     <= '0;
      lc_q     <= '0;
      h_q      <= '0;
      l_q      <= '0;
      k_q      <= '0;
      free_q   <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_xfer) begin
            loaded_q <= loaded_q + 1'b1;
            if (s_axis_tuser_i) begin
              lc_q <= lc_q + 1'b1;
            end else begin
              hc_q <= hc_q + 1'b1;
            end
          end
          h_q    <= '0;
          l_q    <= '0;
          k_q    <= '0;
          free_q <= '0;
        end
        ST_ADD: begin
          free_q <= res.sum;
          h_q    <= h_nxt;
          l_q    <= l_nxt;
        end
        ST_OUT: begin
          if (out_xfer) begin
            k_q <= k_q + 1'b1;
            if (m_axis_tlast_o) begin
              loaded_q <= '0;
              hc_q     <= '0;
              lc_q     <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_CMP_A: flag_q <= res.lt;
      ST_CMP_F: begin
        take_low_q <= take_low;
        sel_idx_q  <= take_low ? lo_idx_q : hi_idx_q;
        sel_arr_q  <= {{PAD_W{1'b0}}, take_low ? lo_arr_q : hi_arr_q};
        sel_svc_q  <= {{PAD_W{1'b0}}, take_low ? lo_svc_q : hi_svc_q};
      end
      ST_MAX: start_q <= res.lt ? sel_arr_q : free_q;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      arr_mem[loaded_q[IDX_W-1:0]] <= s_axis_tdata_i[TIME_BITS-1:0];
      svc_mem[loaded_q[IDX_W-1:0]] <= s_axis_tdata_i[32 +: TIME_BITS];
    end
    hi_arr_q <= arr_mem[hi_idx_q];
    lo_arr_q <= arr_mem[lo_idx_q];
    hi_svc_q <= svc_mem[hi_idx_q];
    lo_svc_q <= svc_mem[lo_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !s_axis_tuser_i) begin
      hi_list[hc_q[IDX_W-1:0]] <= loaded_q[IDX_W-1:0];
    end
    hi_idx_q <= hi_list[h_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tuser_i) begin
      lo_list[lc_q[IDX_W-1:0]] <= loaded_q[IDX_W-1:0];
    end
    lo_idx_q <= lo_list[l_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADD) begin
      cmp_mem[sel_idx_q] <= res.sum;
    end
    rd_q <= cmp_mem[k_q[IDX_W-1:0]];
  end

endmodule

[bench/ptct_checker.sv]
// Checker: watches both channels, predicts completion times per batch and compares results.
`timescale 1ns / 100ps

module ptct_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_i,
  input  logic [ptct_pkg::IN_W-1:0]   s_axis_tdata_i,   // arrival_time, service_time
  input  logic                        s_axis_tuser_i,   // low_class
  input  logic                        s_axis_tlast_i,   // last_task
  input  logic                        m_axis_tvalid_i,
  input  logic                        m_axis_tready_i,
  input  logic [ptct_pkg::OUT_W-1:0]  m_axis_tdata_i,   // task_index, completion_time, zero pad
  input  logic                        m_axis_tlast_i,   // last_result
  output int                          errors_o,
  output int                          pending_o
);
  import ptct_pkg::*;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic [DONE_W-1:0]    done;
    logic                 last;
  } completion_t;

  completion_t          due_q[$];
  logic [TIME_BITS-1:0] arr_mem [MAX_TASKS];
  logic [TIME_BITS-1:0] svc_mem [MAX_TASKS];
  logic                 low_mem [MAX_TASKS];
  int                   n_loaded = 0;
  int                   err_cnt  = 0;

  assign errors_o = err_cnt;

  // non-preemptive two-class schedule over the loaded batch
  function automatic void schedule_batch(input int n);
    logic [DONE_W-1:0] free_t;
    logic [DONE_W-1:0] start_t;
    logic [DONE_W:0]   sum;
    logic [DONE_W-1:0] fin [MAX_TASKS];
    int                hi_q[$];
    int                lo_q[$];
    int                pick;
    bit                take_lo;
    completion_t       c;
    free_t = '0;
    for (int k = 0; k < n; k++) begin
      if (low_mem[k]) lo_q.insert(lo_q.size(), k);
      else hi_q.insert(hi_q.size(), k);
    end
    while (hi_q.size() != 0 || lo_q.size() != 0) begin
      if (lo_q.size() == 0) take_lo = 1'b0;
      else if (hi_q.size() == 0) take_lo = 1'b1;
      else take_lo = (arr_mem[lo_q[0]] < arr_mem[hi_q[0]]) && (free_t < arr_mem[hi_q[0]]);
      if (take_lo) pick = lo_q.pop_front();
      else pick = hi_q.pop_front();
      start_t = (DONE_W'(arr_mem[pick]) > free_t) ? DONE_W'(arr_mem[pick]) : free_t;
      sum     = {1'b0, start_t} + (DONE_W + 1)'(svc_mem[pick]);
      free_t  = sum[DONE_W] ? '1 : sum[DONE_W-1:0];   // saturate
      fin[pick] = free_t;
    end
    for (int k = 0; k < n; k++) begin
      c.idx  = OUT_IDX_W'(k);
      c.done = fin[k];
      c.last = (k == n - 1);
      due_q.insert(due_q.size(), c);
    end
  endfunction

  always @(posedge clk_i) begin
    completion_t exp_c;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        arr_mem[n_loaded] = s_axis_tdata_i[TIME_BITS-1:0];
        svc_mem[n_loaded] = s_axis_tdata_i[2*TIME_BITS-1:TIME_BITS];
        low_mem[n_loaded] = s_axis_tuser_i;
        n_loaded++;
        if (s_axis_tlast_i || n_loaded == MAX_TASKS) begin
          schedule_batch(n_loaded);
          n_loaded = 0;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_q.size() == 0) begin
          err_cnt++;
          $error("result transfer with nothing expected: task_index %0d, completion_time %0d",
                 m_axis_tdata_i[OUT_IDX_W-1:0], m_axis_tdata_i[OUT_IDX_W+DONE_W-1:OUT_IDX_W]);
        end else begin
          exp_c = due_q.pop_front();
          if (m_axis_tdata_i[OUT_IDX_W-1:0] !== exp_c.idx) begin
            err_cnt++;
            $error("task_index: expected %0d, got %0d", exp_c.idx,
                   m_axis_tdata_i[OUT_IDX_W-1:0]);
          end
          if (m_axis_tdata_i[OUT_IDX_W+DONE_W-1:OUT_IDX_W] !== exp_c.done) begin
            err_cnt++;
            $error("completion_time: expected %0d, got %0d", exp_c.done,
                   m_axis_tdata_i[OUT_IDX_W+DONE_W-1:OUT_IDX_W]);
          end
          if (m_axis_tlast_i !== exp_c.last) begin
            err_cnt++;
            $error("last_result: expected %0b, got %0b", exp_c.last, m_axis_tlast_i);
          end
          if (m_axis_tdata_i[OUT_W-1:OUT_IDX_W+DONE_W] !== '0) begin
            err_cnt++;
            $error("pad: expected 0, got %0h", m_axis_tdata_i[OUT_W-1:OUT_IDX_W+DONE_W]);
          end
        end
      end
    end
    pending_o <= due_q.size();
  end

endmodule

[bench/tb_top.sv]
// Testbench top: clock, reset, task batch stimulus, receiver back-pressure and verdict.
`timescale 1ns / 100ps

module tb_top;
  import ptct_pkg::*;

  localparam int LIMIT        = 300000;
  localparam int HOLD_CYCLES  = 500;
  localparam int TARGET_ITEMS = 130;

  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             s_tuser  = 1'b0;
  logic             s_tlast  = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  int errors;
  int pending;
  int cycle_cnt   = 0;
  int items_sent  = 0;
  bit no_gaps     = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  always #4 clk = ~clk;

  priority_task_completion_times u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  ptct_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 90);
  endfunction

  function automatic logic [31:0] rand_time(input int mode);
    case (mode)
      0:       return 32'($urandom_range(0, 40));
      1:       return 32'($urandom_range(0, 2000));
      2:       return $urandom;
      default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_task(input logic [31:0] arr, input logic [31:0] svc,
                           input logic lo, input logic lst);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {svc, arr};
    s_tuser  <= lo;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mode 4 mixes the value ranges task by task
  task automatic send_batch(input int n, input bit no_last, input int mode);
    int cls_pct;
    int m;
    cls_pct = $urandom_range(0, 100);
    for (int k = 0; k < n; k++) begin
      m = (mode == 4) ? $urandom_range(0, 3) : mode;
      send_task(rand_time(m), rand_time(m), ($urandom_range(0, 99) < cls_pct),
                no_last ? 1'b0 : (k == n - 1));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 65) return 1;
    if (r < 80) return 2;
    if (r < 88) return 3;
    return 4;
  endfunction

  // receiver
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single tasks at the field extremes
    send_task(32'd0, 32'd0, 1'b0, 1'b1);
    send_task('1, '1, 1'b1, 1'b1);
    // low ahead of a later high; equal arrival goes to high
    send_task(32'd10, 32'd5, 1'b0, 1'b0);
    send_task(32'd3, 32'd20, 1'b1, 1'b0);
    send_task(32'd10, 32'd1, 1'b1, 1'b0);
    send_task(32'd12, 32'd2, 1'b0, 1'b1);
    // low arrives earlier but the server is busy past the high arrival
    send_task(32'd0, 32'd10, 1'b0, 1'b0);
    send_task(32'd5, 32'd1, 1'b0, 1'b0);
    send_task(32'd1, 32'd1, 1'b1, 1'b1);
    // low class only, arrivals out of order
    send_task(32'd100, 32'd1, 1'b1, 1'b0);
    send_task(32'd0, 32'd2, 1'b1, 1'b1);
    // idle until a late arrival, then a long service
    send_task('1, '1, 1'b0, 1'b0);
    send_task(32'd0, 32'd7, 1'b0, 1'b1);
    send_task(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0);
    send_task(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1);
    wait_drained();

    no_gaps = 1'b1;
    repeat (3) send_batch($urandom_range(2, 8), 1'b0, 0);
    no_gaps = 1'b0;
    wait_drained();

    // store full ends the batch without a last flag
    send_batch(MAX_TASKS, 1'b1, 4);
    wait_drained();

    // long receiver hold while batches keep coming
    hold_req = 1'b1;
    repeat (3) send_batch($urandom_range(3, 10), 1'b0, 0);
    wait_drained();

    while (items_sent < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      send_batch((r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24), 1'b0, pick_mode());
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ptct_pkg.sv
rtl/ptct_unit.sv
rtl/priority_task_completion_times.sv
bench/ptct_checker.sv
bench/tb_top.sv
